// ----- src/assert_macros.svh -----
// ----------------------------------------------------------------------------
// assert_macros: shared assertion shorthands
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// antecedent implies consequent in the same cycle
`define RME_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("assertion failed");

// antecedent implies consequent in the next cycle
`define RME_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("assertion failed");

`endif

// ----- src/rme_pkg.sv -----
// ----------------------------------------------------------------------------
// rme_pkg
// Types, constants and helpers of the rotation matrix to euler block.
// ----------------------------------------------------------------------------
`default_nettype none

package rme_pkg;

	localparam int IN_W              = 16;
	localparam int ANG_W             = 16;
	localparam int EPS_W             = 15;
	localparam int CODE_W            = 2;
	localparam int XY_W              = 20;
	localparam int Z_W               = 22;
	localparam int Q12_W             = Z_W - 4;
	localparam int SUM_W             = Q12_W + 2;
	localparam int N_W               = 29;
	localparam int SQRT_STEPS        = 15;
	localparam int LANES             = 6;
	localparam int TAB_LEN           = 24;
	localparam int CORDIC_STAGES_DEF = 14;
	localparam int ADDR_W            = 2;
	localparam int DATA_W            = 32;

	localparam int PI_Q16      = 205887;
	localparam int HALF_PI_Q16 = 102944;
	localparam int ONE_Q14     = 16384;

	localparam logic [ADDR_W-1:0] ADDR_EPS  = ADDR_W'(0);
	localparam logic [EPS_W-1:0]  EPS_RESET = EPS_W'(1);

	localparam logic signed [ANG_W-1:0] Y_LOCK_M = ANG_W'((HALF_PI_Q16 + 8) >>> 4);
	localparam logic signed [ANG_W-1:0] Y_LOCK_P = ANG_W'((-HALF_PI_Q16 + 8) >>> 4);

	// cordic lanes
	localparam int LANE_ASIN = 0;
	localparam int LANE_X1   = 1;
	localparam int LANE_Z1   = 2;
	localparam int LANE_X2   = 3;
	localparam int LANE_Z2   = 4;
	localparam int LANE_LOCK = 5;

	typedef enum logic [CODE_W-1:0] {
		CASE_GEN1   = 2'd0,
		CASE_GEN2   = 2'd1,
		CASE_LOCK_M = 2'd2,
		CASE_LOCK_P = 2'd3
	} case_t;

	typedef struct packed {
		logic signed [IN_W-1:0] r11;
		logic signed [IN_W-1:0] r12;
		logic signed [IN_W-1:0] r13;
		logic signed [IN_W-1:0] r21;
		logic signed [IN_W-1:0] r23;
		logic signed [IN_W-1:0] r31;
		logic signed [IN_W-1:0] r33;
		case_t                  code;
	} mat_t;

	typedef struct packed {
		logic [N_W-1:0]         n;
		logic [N_W-1:0]         res;
		logic signed [IN_W-1:0] s;
		mat_t                   m;
	} sq_t;

	typedef struct packed {
		logic                   zero;
		logic signed [XY_W-1:0] x;
		logic signed [XY_W-1:0] y;
		logic signed [Z_W-1:0]  z;
	} lane_t;

	function automatic logic signed [Z_W-1:0] atan_tab(input int i);
		logic signed [Z_W-1:0] r;
		case (i)
			0:  r = Z_W'(51472);
			1:  r = Z_W'(30386);
			2:  r = Z_W'(16055);
			3:  r = Z_W'(8150);
			4:  r = Z_W'(4091);
			5:  r = Z_W'(2047);
			6:  r = Z_W'(1024);
			7:  r = Z_W'(512);
			8:  r = Z_W'(256);
			9:  r = Z_W'(128);
			10: r = Z_W'(64);
			11: r = Z_W'(32);
			12: r = Z_W'(16);
			13: r = Z_W'(8);
			14: r = Z_W'(4);
			15: r = Z_W'(2);
			16: r = Z_W'(1);
			default: r = '0;
		endcase
		return r;
	endfunction

	function automatic logic signed [XY_W-1:0] sx(input logic signed [IN_W-1:0] v);
		return {{(XY_W-IN_W){v[IN_W-1]}}, v};
	endfunction

	// fold the left half plane over before the rotations
	function automatic lane_t prerot(input logic signed [XY_W-1:0] y,
			input logic signed [XY_W-1:0] x);
		lane_t r;
		r.zero = (x == '0) && (y == '0);
		if (x[XY_W-1]) begin
			r.x = -x;
			r.y = -y;
			r.z = y[XY_W-1] ? -Z_W'(PI_Q16) : Z_W'(PI_Q16);
		end else begin
			r.x = x;
			r.y = y;
			r.z = '0;
		end
		return r;
	endfunction

	// q.16 to q6.12, round half up
	function automatic logic signed [Q12_W-1:0] to_q12(input logic signed [Z_W-1:0] v);
		logic signed [Z_W-1:0] t;
		t = v + Z_W'(8);
		return Q12_W'(t >>> 4);
	endfunction

endpackage

`default_nettype wire

// ----- src/rme_if.sv -----
// ----------------------------------------------------------------------------
// rme_if
// Channel interfaces: matrix words in, angle words out.
// ----------------------------------------------------------------------------
`default_nettype none

interface rme_mat_if;
	logic                            valid;
	logic                            ready;
	logic signed [rme_pkg::IN_W-1:0] r11;
	logic signed [rme_pkg::IN_W-1:0] r12;
	logic signed [rme_pkg::IN_W-1:0] r13;
	logic signed [rme_pkg::IN_W-1:0] r21;
	logic signed [rme_pkg::IN_W-1:0] r23;
	logic signed [rme_pkg::IN_W-1:0] r31;
	logic signed [rme_pkg::IN_W-1:0] r33;
	modport source (output valid, r11, r12, r13, r21, r23, r31, r33, input ready);
	modport sink (input valid, r11, r12, r13, r21, r23, r31, r33, output ready);
endinterface

interface rme_ang_if;
	logic                             valid;
	logic                             ready;
	logic signed [rme_pkg::ANG_W-1:0] angle_x;
	logic signed [rme_pkg::ANG_W-1:0] angle_y;
	logic signed [rme_pkg::ANG_W-1:0] angle_z;
	logic [rme_pkg::CODE_W-1:0]       case_code;
	modport source (output valid, angle_x, angle_y, angle_z, case_code, input ready);
	modport sink (input valid, angle_x, angle_y, angle_z, case_code, output ready);
endinterface

`default_nettype wire

// ----- src/rme_sqrt_cell.sv -----
// ----------------------------------------------------------------------------
// rme_sqrt_cell
// One digit step of the integer square root, registered.
// ----------------------------------------------------------------------------
`default_nettype none

module rme_sqrt_cell #(
	parameter int K = 0
) (
	input  wire logic         clk,
	input  wire logic         ce,
	input  wire rme_pkg::sq_t d,
	output rme_pkg::sq_t      q
);

	localparam logic [rme_pkg::N_W-1:0] BIT = rme_pkg::N_W'(1) << (2 * K);

	rme_pkg::sq_t nxt;
	logic [rme_pkg::N_W-1:0] trial;

	always_comb begin
		nxt = d;
		trial = d.res + BIT;
		if (d.n >= trial) begin
			nxt.n = d.n - trial;
			nxt.res = (d.res >> 1) + BIT;
		end else begin
			nxt.res = d.res >> 1;
		end
	end

	always_ff @(posedge clk) begin
		if (ce) begin
			q <= nxt;
		end
	end

endmodule

`default_nettype wire

// ----- src/rme_cordic_cell.sv -----
// ----------------------------------------------------------------------------
// rme_cordic_cell
// One vectoring cordic rotation of one lane, registered.
// ----------------------------------------------------------------------------
`default_nettype none

module rme_cordic_cell #(
	parameter int STAGE = 0
) (
	input  wire logic          clk,
	input  wire logic          ce,
	input  wire rme_pkg::lane_t d,
	output rme_pkg::lane_t     q
);

	localparam logic signed [rme_pkg::Z_W-1:0] TAB = rme_pkg::atan_tab(STAGE);

	rme_pkg::lane_t nxt;
	logic signed [rme_pkg::XY_W-1:0] xs;
	logic signed [rme_pkg::XY_W-1:0] ys;

	always_comb begin
		xs = d.x >>> STAGE;
		ys = d.y >>> STAGE;
		nxt.zero = d.zero;
		if (!d.y[rme_pkg::XY_W-1]) begin
			nxt.x = d.x + ys;
			nxt.y = d.y - xs;
			nxt.z = d.z + TAB;
		end else begin
			nxt.x = d.x - ys;
			nxt.y = d.y + xs;
			nxt.z = d.z - TAB;
		end
	end

	always_ff @(posedge clk) begin
		if (ce) begin
			q <= nxt;
		end
	end

endmodule

`default_nettype wire

// ----- src/rotation_matrix_to_euler.sv -----
// ----------------------------------------------------------------------------
// rotation_matrix_to_euler
// XYZ euler angles from a rotation matrix, one matrix per cycle.
// ----------------------------------------------------------------------------
// Usage:
//   mat carries seven matrix entries in Q2.14 as one word; ang returns
//   angle_x, angle_y, angle_z in Q4.12 radians and a case code.
//   lock_epsilon sits at APB byte address 0; the user is to have it written
//   only while idle, which the block itself does not enforce. A matrix word
//   goes through an input register, the lock test and square stage, 15
//   square root digit cells, a fold stage, CORDIC_STAGES cordic cells in
//   six parallel lanes, a rounding stage and the output register.
//   One word is taken each cycle while the receiver does not stall; the
//   cell chain sets that figure, as every cell hands its word on each cycle.
//   When the receiver stalls with a result waiting, the whole chain holds
//   and mat.ready drops; words already inside are kept, none is lost.
//   Reset clears all valid bits and sets lock_epsilon to 1.
// ----------------------------------------------------------------------------
`default_nettype none

`include "assert_macros.svh"

module rotation_matrix_to_euler #(
	parameter int CORDIC_STAGES = rme_pkg::CORDIC_STAGES_DEF
) (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	input  wire logic                         psel,
	input  wire logic                         penable,
	input  wire logic                         pwrite,
	input  wire logic [rme_pkg::ADDR_W-1:0]   paddr,
	input  wire logic [rme_pkg::DATA_W-1:0]   pwdata,
	output logic [rme_pkg::DATA_W-1:0]        prdata,
	output logic                              pready,
	rme_mat_if.sink                           mat,
	rme_ang_if.source                         ang
);

	localparam int DEPTH = rme_pkg::SQRT_STEPS + CORDIC_STAGES + 4;
	localparam int V_S2  = 1;
	localparam int V_S3  = rme_pkg::SQRT_STEPS + 2;
	localparam int V_S4  = DEPTH - 1;

	// config register
	logic [rme_pkg::EPS_W-1:0] eps_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			eps_q <= rme_pkg::EPS_RESET;
		end else if (psel && penable && pwrite && paddr == rme_pkg::ADDR_EPS) begin
			eps_q <= pwdata[rme_pkg::EPS_W-1:0];
		end
	end

	assign pready = 1'b1;
	assign prdata = (paddr == rme_pkg::ADDR_EPS) ?
		{{(rme_pkg::DATA_W-rme_pkg::EPS_W){1'b0}}, eps_q} : '0;

	// flow control: the whole chain moves together
	logic             ce;
	logic [DEPTH-1:0] v_q;
	logic             out_valid_q;

	assign ce = !out_valid_q || ang.ready;
	assign mat.ready = ce;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_q <= '0;
			out_valid_q <= 1'b0;
		end else if (ce) begin
			v_q <= {v_q[DEPTH-2:0], mat.valid};
			out_valid_q <= v_q[DEPTH-1];
		end
	end

	// input register
	rme_pkg::mat_t mat_s1;

	always_ff @(posedge clk) begin
		if (ce) begin
			mat_s1.r11 <= mat.r11;
			mat_s1.r12 <= mat.r12;
			mat_s1.r13 <= mat.r13;
			mat_s1.r21 <= mat.r21;
			mat_s1.r23 <= mat.r23;
			mat_s1.r31 <= mat.r31;
			mat_s1.r33 <= mat.r33;
			mat_s1.code <= rme_pkg::CASE_GEN1;
		end
	end

	// lock test, clamp and square
	logic signed [rme_pkg::IN_W:0]     sum_m;
	logic signed [rme_pkg::IN_W:0]     sum_p;
	logic [rme_pkg::IN_W:0]            mag_m;
	logic [rme_pkg::IN_W:0]            mag_p;
	logic                              lock_m;
	logic                              lock_p;
	logic signed [rme_pkg::IN_W-1:0]   s_cl;
	logic signed [2*rme_pkg::IN_W-1:0] prod;
	rme_pkg::sq_t                      sq_d;
	rme_pkg::sq_t                      sq [rme_pkg::SQRT_STEPS+1];

	always_comb begin
		sum_m = {mat_s1.r13[rme_pkg::IN_W-1], mat_s1.r13} + (rme_pkg::IN_W+1)'(rme_pkg::ONE_Q14);
		sum_p = {mat_s1.r13[rme_pkg::IN_W-1], mat_s1.r13} - (rme_pkg::IN_W+1)'(rme_pkg::ONE_Q14);
		mag_m = sum_m[rme_pkg::IN_W] ? -sum_m : sum_m;
		mag_p = sum_p[rme_pkg::IN_W] ? -sum_p : sum_p;
		lock_m = mag_m < {2'b00, eps_q};
		lock_p = mag_p < {2'b00, eps_q};
		if (mat_s1.r13 > rme_pkg::IN_W'(rme_pkg::ONE_Q14)) begin
			s_cl = rme_pkg::IN_W'(rme_pkg::ONE_Q14);
		end else if (mat_s1.r13 < -rme_pkg::IN_W'(rme_pkg::ONE_Q14)) begin
			s_cl = -rme_pkg::IN_W'(rme_pkg::ONE_Q14);
		end else begin
			s_cl = mat_s1.r13;
		end
		prod = s_cl * s_cl;
		sq_d.n = rme_pkg::N_W'(rme_pkg::ONE_Q14 * rme_pkg::ONE_Q14) - prod[rme_pkg::N_W-1:0];
		sq_d.res = '0;
		sq_d.s = s_cl;
		sq_d.m = mat_s1;
		if (lock_m) begin
			sq_d.m.code = rme_pkg::CASE_LOCK_M;
		end else if (lock_p) begin
			sq_d.m.code = rme_pkg::CASE_LOCK_P;
		end else begin
			sq_d.m.code = rme_pkg::CASE_GEN1;
		end
	end

	always_ff @(posedge clk) begin
		if (ce) begin
			sq[0] <= sq_d;
		end
	end

	// square root digit cells
	for (genvar k = 0; k < rme_pkg::SQRT_STEPS; k++) begin : g_sqrt
		rme_sqrt_cell #(
			.K(rme_pkg::SQRT_STEPS - 1 - k)
		) u_cell (
			.clk(clk),
			.ce (ce),
			.d  (sq[k]),
			.q  (sq[k+1])
		);
	end

	// fold stage: operands of the six lanes
	rme_pkg::sq_t   sqo;
	rme_pkg::lane_t pre_d [rme_pkg::LANES];
	rme_pkg::lane_t cl [CORDIC_STAGES+1][rme_pkg::LANES];
	rme_pkg::case_t code_q [CORDIC_STAGES+1];

	assign sqo = sq[rme_pkg::SQRT_STEPS];

	always_comb begin
		pre_d[rme_pkg::LANE_ASIN] = rme_pkg::prerot(rme_pkg::sx(sqo.s),
			rme_pkg::XY_W'(sqo.res));
		pre_d[rme_pkg::LANE_X1] = rme_pkg::prerot(rme_pkg::sx(sqo.m.r23),
			rme_pkg::sx(sqo.m.r33));
		pre_d[rme_pkg::LANE_Z1] = rme_pkg::prerot(rme_pkg::sx(sqo.m.r12),
			rme_pkg::sx(sqo.m.r11));
		pre_d[rme_pkg::LANE_X2] = rme_pkg::prerot(-rme_pkg::sx(sqo.m.r23),
			-rme_pkg::sx(sqo.m.r33));
		pre_d[rme_pkg::LANE_Z2] = rme_pkg::prerot(-rme_pkg::sx(sqo.m.r12),
			-rme_pkg::sx(sqo.m.r11));
		if (sqo.m.code == rme_pkg::CASE_LOCK_M) begin
			pre_d[rme_pkg::LANE_LOCK] = rme_pkg::prerot(rme_pkg::sx(sqo.m.r21),
				rme_pkg::sx(sqo.m.r31));
		end else begin
			pre_d[rme_pkg::LANE_LOCK] = rme_pkg::prerot(-rme_pkg::sx(sqo.m.r21),
				-rme_pkg::sx(sqo.m.r31));
		end
	end

	always_ff @(posedge clk) begin
		if (ce) begin
			cl[0] <= pre_d;
			code_q[0] <= sqo.m.code;
		end
	end

	// cordic cells, six lanes side by side
	for (genvar i = 0; i < CORDIC_STAGES; i++) begin : g_stage
		for (genvar l = 0; l < rme_pkg::LANES; l++) begin : g_lane
			rme_cordic_cell #(
				.STAGE(i)
			) u_cell (
				.clk(clk),
				.ce (ce),
				.d  (cl[i][l]),
				.q  (cl[i+1][l])
			);
		end
		always_ff @(posedge clk) begin
			if (ce) begin
				code_q[i+1] <= code_q[i];
			end
		end
	end

	// rounding stage
	logic signed [rme_pkg::Z_W-1:0] zf [rme_pkg::LANES];
	logic signed [rme_pkg::Z_W-1:0] y1_q16;
	logic signed [rme_pkg::Z_W-1:0] y2_q16;

	always_comb begin
		for (int l = 0; l < rme_pkg::LANES; l++) begin
			zf[l] = cl[CORDIC_STAGES][l].zero ? '0 : cl[CORDIC_STAGES][l].z;
		end
		y1_q16 = -zf[rme_pkg::LANE_ASIN];
		y2_q16 = rme_pkg::Z_W'(rme_pkg::PI_Q16) - y1_q16;
	end

	logic signed [rme_pkg::Q12_W-1:0] x1_s4, z1_s4, x2_s4, z2_s4, y1_s4, y2_s4, lz_s4;
	rme_pkg::case_t                   code_s4;

	always_ff @(posedge clk) begin
		if (ce) begin
			x1_s4 <= rme_pkg::to_q12(zf[rme_pkg::LANE_X1]);
			z1_s4 <= rme_pkg::to_q12(zf[rme_pkg::LANE_Z1]);
			x2_s4 <= rme_pkg::to_q12(zf[rme_pkg::LANE_X2]);
			z2_s4 <= rme_pkg::to_q12(zf[rme_pkg::LANE_Z2]);
			lz_s4 <= rme_pkg::to_q12(zf[rme_pkg::LANE_LOCK]);
			y1_s4 <= rme_pkg::to_q12(y1_q16);
			y2_s4 <= rme_pkg::to_q12(y2_q16);
			code_s4 <= code_q[CORDIC_STAGES];
		end
	end

	// choose the solution and register the result
	function automatic logic [rme_pkg::SUM_W-1:0] mag(input logic signed [rme_pkg::Q12_W-1:0] v);
		logic [rme_pkg::Q12_W-1:0] a;
		a = v[rme_pkg::Q12_W-1] ? -v : v;
		return rme_pkg::SUM_W'(a);
	endfunction

	logic [rme_pkg::SUM_W-1:0] q1;
	logic [rme_pkg::SUM_W-1:0] q2;
	logic signed [rme_pkg::ANG_W-1:0] ax_d, ay_d, az_d;
	rme_pkg::case_t code_d;

	always_comb begin
		q1 = mag(x1_s4) + mag(y1_s4) + mag(z1_s4);
		q2 = mag(x2_s4) + mag(y2_s4) + mag(z2_s4);
		case (code_s4)
			rme_pkg::CASE_LOCK_M: begin
				ax_d = '0;
				ay_d = rme_pkg::Y_LOCK_M;
				az_d = lz_s4[rme_pkg::ANG_W-1:0];
				code_d = rme_pkg::CASE_LOCK_M;
			end
			rme_pkg::CASE_LOCK_P: begin
				ax_d = '0;
				ay_d = rme_pkg::Y_LOCK_P;
				az_d = lz_s4[rme_pkg::ANG_W-1:0];
				code_d = rme_pkg::CASE_LOCK_P;
			end
			default: begin
				if (q1 <= q2) begin
					ax_d = x1_s4[rme_pkg::ANG_W-1:0];
					ay_d = y1_s4[rme_pkg::ANG_W-1:0];
					az_d = z1_s4[rme_pkg::ANG_W-1:0];
					code_d = rme_pkg::CASE_GEN1;
				end else begin
					ax_d = x2_s4[rme_pkg::ANG_W-1:0];
					ay_d = y2_s4[rme_pkg::ANG_W-1:0];
					az_d = z2_s4[rme_pkg::ANG_W-1:0];
					code_d = rme_pkg::CASE_GEN2;
				end
			end
		endcase
	end

	logic signed [rme_pkg::ANG_W-1:0] ax_q, ay_q, az_q;
	rme_pkg::case_t                   code_out_q;

	always_ff @(posedge clk) begin
		if (ce) begin
			ax_q <= ax_d;
			ay_q <= ay_d;
			az_q <= az_d;
			code_out_q <= code_d;
		end
	end

	assign ang.valid = out_valid_q;
	assign ang.angle_x = ax_q;
	assign ang.angle_y = ay_q;
	assign ang.angle_z = az_q;
	assign ang.case_code = code_out_q;

	// a word taken lands in the first stage
	`RME_ASSERT_NEXT(a_accept_to_s1, clk, arst_n, mat.valid && mat.ready, v_q[0])
	// input stalls only behind a waiting result
	`RME_ASSERT_IMP(a_stall_when_full, clk, arst_n, mat.valid && !mat.ready, ang.valid)
	// gimbal lock words carry no x rotation
	`RME_ASSERT_IMP(a_lock_x_zero, clk, arst_n,
		ang.valid && (ang.case_code == rme_pkg::CASE_LOCK_M || ang.case_code == rme_pkg::CASE_LOCK_P),
		ang.angle_x == '0)
	// lock minus one gives y of plus half pi
	`RME_ASSERT_IMP(a_lock_m_y, clk, arst_n,
		ang.valid && ang.case_code == rme_pkg::CASE_LOCK_M, ang.angle_y == rme_pkg::Y_LOCK_M)
	// stage valid bits follow each other through the fold and rounding stages
	`RME_ASSERT_NEXT(a_s4_from_s3, clk, arst_n,
		ce && v_q[V_S3] && !v_q[V_S2], v_q[V_S3 + 1] && (v_q[V_S4] == $past(v_q[V_S4 - 1])))

endmodule

`default_nettype wire
